// ===== hdl/ihs_pkg.sv =====
// Shared types and constants of the tagged integer heapsort block.
// No dependencies; used by the top level int_heapsort_with_tags.
package ihs_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned TAG_W = 32;
  localparam int unsigned ENTRY_W = KEY_W + TAG_W;

  // One stored pair: key in the upper half, tag in the lower half
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
  } entry_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_LOAD,      // collecting items, not busy
    S_BUILD_RD,  // heap build: read the node to sift
    S_BUILD_CAP, // heap build: capture that node
    S_SIFT_L,    // sift level: check depth, read left child
    S_SIFT_R,    // sift level: capture left, read right child
    S_CMP_SEL,   // compare left and right child, keep the larger
    S_CMP_MOVE,  // compare sifted value and child, move or settle
    S_PUT,       // sifted value reached the bottom, write it
    S_EX_RD0,    // extraction: read the root
    S_EX_RDN,    // extraction: capture root, read last heap entry
    S_EX_SWAP,   // extraction: root to the end, last entry starts sifting
    S_OUT        // stream sorted pairs out
  } state_e;

endpackage

// ===== hdl/ihs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used by int_heapsort_with_tags as the pair store.
module ihs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/int_heapsort_with_tags.sv =====
// Top level of the tagged integer heapsort block: loader, heap sequencer, output streamer.
// Depends on ihs_pkg (types, states) and ihs_ram (pair store).

// Items (key, tag, last_item) are taken one per cycle while busy is low. Up to DEPTH
// pairs are stored; further items are dropped and raise overflow on every result of
// that set. The item flagged last starts an in-place max-heap sort of the stored pairs
// in one RAM with a single read and a single write port, driven by a small sequencer
// and one shared signed comparator. Each sift level reads the left child, reads the right
// child, picks the larger child, then compares and moves; building sifts down every node
// from the last parent to the root, and extraction runs N-1 sift-downs, each after the
// root is swapped to the end of the heap and the last heap entry starts sifting down.
// Results come out on consecutive cycles, each marked by strobe_o for one cycle, in
// ascending key order; the receiver cannot stall them. busy stays high from the last
// item until the final result is on the ports; the next item may be taken in that cycle.
module int_heapsort_with_tags #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [ihs_pkg::KEY_W-1:0] key_i,
  input  logic        [ihs_pkg::TAG_W-1:0] tag_i,
  input  logic                            last_item_i,
  output logic                            strobe_o,
  output logic signed [ihs_pkg::KEY_W-1:0] sorted_key_o,
  output logic        [ihs_pkg::TAG_W-1:0] sorted_tag_o,
  output logic                            last_result_o,
  output logic                            overflow_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ihs_pkg::state_e state_q, state_d;

  // Control registers
  logic [CW-1:0] count_q, count_d;     // pairs held in the store
  logic          dropped_q, dropped_d; // an item of this set was dropped
  logic [AW-1:0] n_q, n_d;             // last index of the heap
  logic [AW-1:0] kb_q, kb_d;           // build: node being sifted
  logic          bq_q, bq_d;           // build phase in progress
  logic [AW-1:0] k_q, k_d;             // current hole position
  logic [AW-1:0] cs_q, cs_d;           // chosen child index
  logic [AW-1:0] i_q, i_d;             // output index
  logic          strobe_q, strobe_d;
  logic          last_q, last_d;
  logic          ovf_q, ovf_d;

  // Payload registers
  ihs_pkg::entry_t p_q, p_d;   // value being sifted down
  ihs_pkg::entry_t l_q, l_d;   // left child
  ihs_pkg::entry_t ch_q, ch_d; // larger child, or saved root

  // Store port signals
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  ihs_pkg::entry_t ram_wdata;
  logic [AW-1:0]   ram_raddr;
  ihs_pkg::entry_t ram_rdata;

  ihs_ram #(
    .WIDTH (ihs_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Load-side helpers
  logic          accept;
  logic          store_ok;
  logic [CW-1:0] cnt_new;
  logic [AW-1:0] n_new;
  logic [AW-1:0] cnt_m1;

  assign accept   = start && (state_q == ihs_pkg::S_LOAD);
  assign store_ok = count_q < CW'(DEPTH);
  assign cnt_new  = count_q + CW'(store_ok);
  assign n_new    = AW'(cnt_new - CW'(1));
  assign cnt_m1   = AW'(count_q - CW'(1));

  // Child addressing of the current hole
  logic [AW-1:0] c_w;
  logic [AW-1:0] c_p1;
  logic          c_lt_n;
  logic          below_leaf;

  assign c_w        = k_q << 1;
  assign c_p1       = c_w + AW'(1);
  assign c_lt_n     = c_w < n_q;
  assign below_leaf = k_q > (n_q >> 1);

  // Shared signed comparator: a < b
  logic signed [ihs_pkg::KEY_W-1:0] cmp_a, cmp_b;
  logic                             cmp_lt;

  always_comb begin
    if (state_q == ihs_pkg::S_CMP_MOVE) begin
      cmp_a = p_q.key;
      cmp_b = ch_q.key;
    end else begin
      cmp_a = l_q.key;
      cmp_b = ram_rdata.key;
    end
  end

  assign cmp_lt = cmp_a < cmp_b;

  // Where to go once a sift-down has settled
  ihs_pkg::state_e fin_state;

  always_comb begin
    if (bq_q && (kb_q != '0)) begin
      fin_state = ihs_pkg::S_BUILD_RD;
    end else if (n_q != '0) begin
      fin_state = ihs_pkg::S_EX_RD0;
    end else begin
      fin_state = ihs_pkg::S_OUT;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ihs_pkg::S_LOAD: begin
        if (accept && last_item_i) begin
          state_d = (cnt_new < CW'(2)) ? ihs_pkg::S_OUT : ihs_pkg::S_BUILD_RD;
        end
      end
      ihs_pkg::S_BUILD_RD:  state_d = ihs_pkg::S_BUILD_CAP;
      ihs_pkg::S_BUILD_CAP: state_d = ihs_pkg::S_SIFT_L;
      ihs_pkg::S_SIFT_L: begin
        state_d = below_leaf ? ihs_pkg::S_PUT : ihs_pkg::S_SIFT_R;
      end
      ihs_pkg::S_SIFT_R:   state_d = ihs_pkg::S_CMP_SEL;
      ihs_pkg::S_CMP_SEL:  state_d = ihs_pkg::S_CMP_MOVE;
      ihs_pkg::S_CMP_MOVE: state_d = cmp_lt ? ihs_pkg::S_SIFT_L : fin_state;
      ihs_pkg::S_PUT:      state_d = fin_state;
      ihs_pkg::S_EX_RD0:   state_d = ihs_pkg::S_EX_RDN;
      ihs_pkg::S_EX_RDN:   state_d = ihs_pkg::S_EX_SWAP;
      ihs_pkg::S_EX_SWAP:  state_d = ihs_pkg::S_SIFT_L;
      ihs_pkg::S_OUT: begin
        if (i_q == cnt_m1) begin
          state_d = ihs_pkg::S_LOAD;
        end
      end
      default: state_d = ihs_pkg::S_LOAD;
    endcase
  end

  // Datapath and store control per state
  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    n_d       = n_q;
    kb_d      = kb_q;
    bq_d      = bq_q;
    k_d       = k_q;
    cs_d      = cs_q;
    i_d       = i_q;
    p_d       = p_q;
    l_d       = l_q;
    ch_d      = ch_q;
    strobe_d  = 1'b0;
    last_d    = 1'b0;
    ovf_d     = ovf_q;
    ram_we    = 1'b0;
    ram_waddr = k_q;
    ram_wdata = p_q;
    ram_raddr = c_w;

    case (state_q)
      ihs_pkg::S_LOAD: begin
        if (accept) begin
          ram_we    = store_ok;
          ram_waddr = AW'(count_q);
          ram_wdata = '{key: key_i, tag: tag_i};
          count_d   = cnt_new;
          dropped_d = dropped_q | ~store_ok;
          if (last_item_i) begin
            n_d  = n_new;
            kb_d = n_new >> 1;
            bq_d = 1'b1;
            i_d  = '0;
          end
        end
      end
      ihs_pkg::S_BUILD_RD: begin
        ram_raddr = kb_q;
      end
      ihs_pkg::S_BUILD_CAP: begin
        p_d = ram_rdata;
        k_d = kb_q;
      end
      ihs_pkg::S_SIFT_L: begin
        ram_raddr = c_w;
      end
      ihs_pkg::S_SIFT_R: begin
        // the root's first child is itself: the stored copy there is stale
        l_d       = (k_q == '0) ? p_q : ram_rdata;
        ram_raddr = c_p1;
      end
      ihs_pkg::S_CMP_SEL: begin
        if (c_lt_n && cmp_lt) begin
          ch_d = ram_rdata;
          cs_d = c_p1;
        end else begin
          ch_d = l_q;
          cs_d = c_w;
        end
      end
      ihs_pkg::S_CMP_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        if (cmp_lt) begin
          ram_wdata = ch_q;
          k_d       = cs_q;
        end else begin
          ram_wdata = p_q;
          if (bq_q && (kb_q != '0)) begin
            kb_d = kb_q - AW'(1);
          end else begin
            bq_d = 1'b0;
          end
        end
      end
      ihs_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = p_q;
        if (bq_q && (kb_q != '0)) begin
          kb_d = kb_q - AW'(1);
        end else begin
          bq_d = 1'b0;
        end
      end
      ihs_pkg::S_EX_RD0: begin
        ram_raddr = '0;
      end
      ihs_pkg::S_EX_RDN: begin
        ch_d      = ram_rdata;
        ram_raddr = n_q;
      end
      ihs_pkg::S_EX_SWAP: begin
        p_d       = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = n_q;
        ram_wdata = ch_q;
        n_d       = n_q - AW'(1);
        k_d       = '0;
      end
      ihs_pkg::S_OUT: begin
        ram_raddr = i_q;
        strobe_d  = 1'b1;
        last_d    = (i_q == cnt_m1);
        ovf_d     = dropped_q;
        if (i_q == cnt_m1) begin
          i_d       = '0;
          count_d   = '0;
          dropped_d = 1'b0;
        end else begin
          i_d = i_q + AW'(1);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ihs_pkg::S_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
      n_q       <= '0;
      kb_q      <= '0;
      bq_q      <= 1'b0;
      k_q       <= '0;
      cs_q      <= '0;
      i_q       <= '0;
      strobe_q  <= 1'b0;
      last_q    <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      n_q       <= n_d;
      kb_q      <= kb_d;
      bq_q      <= bq_d;
      k_q       <= k_d;
      cs_q      <= cs_d;
      i_q       <= i_d;
      strobe_q  <= strobe_d;
      last_q    <= last_d;
      ovf_q     <= ovf_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    l_q  <= l_d;
    ch_q <= ch_d;
  end

  // Outputs: result pair comes straight from the store's read register
  assign busy          = (state_q != ihs_pkg::S_LOAD);
  assign strobe_o      = strobe_q;
  assign sorted_key_o  = ram_rdata.key;
  assign sorted_tag_o  = ram_rdata.tag;
  assign last_result_o = last_q;
  assign overflow_o    = ovf_q;

  // Assertions
  a_strobe_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(state_q == ihs_pkg::S_OUT))
    else $error("result strobe without a preceding output read");

  a_busy_ends_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (strobe_o && last_result_o))
    else $error("busy dropped without the final result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("item count beyond store depth");

  a_hole_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ihs_pkg::S_CMP_MOVE) |-> ((k_q <= n_q) && (cs_q <= n_q)))
    else $error("sift position outside the heap");

endmodule

// ===== test/tb_top.sv =====
// Testbench for int_heapsort_with_tags: random and directed sets of (key, tag) items.
// Predicts the ascending heapsort order, tie order included, and checks every result.
// Depends on ihs_pkg and the int_heapsort_with_tags RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEY_W = ihs_pkg::KEY_W;
  localparam int unsigned TAG_W = ihs_pkg::TAG_W;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned TARGET_ITEMS = 450;
  localparam int unsigned STALL_LIMIT = 20000;  // must exceed the quiet stretch of a full 64-entry sort
  localparam int unsigned DRAIN_CYCLES = 64;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
    logic                    last;
    int unsigned             idle_pct;  // chance of a sender gap before this item
  } load_item_t;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
    logic                    last;
    logic                    ovf;
  } sorted_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic signed [KEY_W-1:0] key_i = '0;
  logic [TAG_W-1:0] tag_i = '0;
  logic last_item_i = 1'b0;
  logic busy;
  logic strobe_o;
  logic signed [KEY_W-1:0] sorted_key_o;
  logic [TAG_W-1:0] sorted_tag_o;
  logic last_result_o;
  logic overflow_o;

  load_item_t item_q[$];
  sorted_pair_t sorted_exp_q[$];
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_queued = 0;

  // Predictor state: the set being collected
  logic signed [KEY_W-1:0] set_keys[STORE_DEPTH];
  logic [TAG_W-1:0] set_tags[STORE_DEPTH];
  int unsigned set_count = 0;
  logic set_dropped = 1'b0;

  int_heapsort_with_tags #(
    .DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .key_i(key_i),
    .tag_i(tag_i),
    .last_item_i(last_item_i),
    .strobe_o(strobe_o),
    .sorted_key_o(sorted_key_o),
    .sorted_tag_o(sorted_tag_o),
    .last_result_o(last_result_o),
    .overflow_o(overflow_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void swap_pair(int unsigned a, int unsigned b);
    logic signed [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    k = set_keys[a]; set_keys[a] = set_keys[b]; set_keys[b] = k;
    t = set_tags[a]; set_tags[a] = set_tags[b]; set_tags[b] = t;
  endfunction

  // Max-heap sift-down over entries 0..n; node k has children 2k and 2k+1
  function automatic void sift_heap(int unsigned n, int unsigned k);
    int unsigned c;
    while (k <= n / 2) begin
      c = 2 * k;
      if (c < n && set_keys[c] < set_keys[c + 1]) c++;
      if (set_keys[k] < set_keys[c]) begin
        swap_pair(k, c);
        k = c;
      end else begin
        break;
      end
    end
  endfunction

  // Store one accepted item; a last item sorts the set and queues its sorted pairs
  function automatic void store_and_sort(logic signed [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                                         logic last);
    sorted_pair_t pair;
    int unsigned n;
    int unsigned k;
    int unsigned i;
    if (set_count < STORE_DEPTH) begin
      set_keys[set_count] = key;
      set_tags[set_count] = tag;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      if (set_count > 1) begin
        n = set_count - 1;
        k = n / 2 + 1;
        do begin
          k--;
          sift_heap(n, k);
        end while (k > 0);
        while (n > 0) begin
          swap_pair(0, n);
          n--;
          sift_heap(n, 0);
        end
      end
      for (i = 0; i < set_count; i++) begin
        pair.key = set_keys[i];
        pair.tag = set_tags[i];
        pair.last = (i + 1 == set_count);
        pair.ovf = set_dropped;
        sorted_exp_q.push_back(pair);
      end
      set_count = 0;
      set_dropped = 1'b0;
    end
  endfunction

  function automatic void push_item(logic signed [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                                    logic last, int unsigned idle_pct);
    load_item_t it;
    it.key = key;
    it.tag = tag;
    it.last = last;
    it.idle_pct = idle_pct;
    item_q.push_back(it);
    items_queued++;
  endfunction

  // Random set: keys mix full range, a narrow band for ties, and the extremes
  function automatic void push_random_set(int unsigned size, int unsigned idle_pct,
                                          bit narrow);
    logic signed [KEY_W-1:0] key;
    int unsigned r;
    int unsigned i;
    for (i = 0; i < size; i++) begin
      r = $urandom_range(0, 9);
      if (narrow || r >= 6) key = KEY_W'(int'($urandom_range(0, 4)) - 2);
      else if (r == 5) key = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      else key = $urandom();
      push_item(key, $urandom(), i + 1 == size, idle_pct);
    end
  endfunction

  // Driver: presents queued items, holds them while busy, random gaps per phase
  always @(posedge clk_i) begin : drive_proc
    load_item_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) store_and_sort(key_i, tag_i, last_item_i);
      if (!start || !busy) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= item_q[0].idle_pct) begin
          nxt = item_q.pop_front();
          start <= 1'b1;
          key_i <= nxt.key;
          tag_i <= nxt.tag;
          last_item_i <= nxt.last;
        end else begin
          // idle: noise on the payload must be ignored
          start <= 1'b0;
          key_i <= $urandom();
          tag_i <= $urandom();
          last_item_i <= $urandom_range(0, 1);
        end
      end
    end
  end

  // Monitor: every strobed result against the oldest expected pair
  always @(posedge clk_i) begin : check_proc
    sorted_pair_t exp_pair;
    if (rst_ni && strobe_o) begin
      if (sorted_exp_q.size() == 0) begin
        $error("result with nothing expected: key %0d tag %0h", sorted_key_o, sorted_tag_o);
        err_count++;
      end else begin
        exp_pair = sorted_exp_q.pop_front();
        if (sorted_key_o !== exp_pair.key) begin
          $error("sorted_key: expected %0d, got %0d", exp_pair.key, sorted_key_o);
          err_count++;
        end
        if (sorted_tag_o !== exp_pair.tag) begin
          $error("sorted_tag: expected %0h, got %0h", exp_pair.tag, sorted_tag_o);
          err_count++;
        end
        if (last_result_o !== exp_pair.last) begin
          $error("last_result: expected %0b, got %0b", exp_pair.last, last_result_o);
          err_count++;
        end
        if (overflow_o !== exp_pair.ovf) begin
          $error("overflow: expected %0b, got %0b", exp_pair.ovf, overflow_o);
          err_count++;
        end
      end
    end
  end

  // Watchdog: too long without an accepted item or result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_proc
    int unsigned phase;
    int unsigned size;
    int unsigned pct_by_phase[4];
    pct_by_phase = '{0, 48, 0, 15};

    // Directed: single-item sets at the extremes
    push_item(32'sh80000000, 32'hffffffff, 1'b1, 0);
    push_item(32'sh7fffffff, 32'h00000000, 1'b1, 0);
    // Extremes, zero, and ties on equal keys
    push_item(32'sh7fffffff, 32'h0, 1'b0, 0);
    push_item(32'sh80000000, 32'h1, 1'b0, 0);
    push_item(32'sh00000000, 32'h2, 1'b0, 0);
    push_item(-32'sd1,       32'h3, 1'b0, 0);
    push_item(32'sd1,        32'h4, 1'b0, 0);
    push_item(32'sd7,        32'h5, 1'b0, 0);
    push_item(32'sd7,        32'h6, 1'b0, 0);
    push_item(32'sd7,        32'h7, 1'b0, 0);
    push_item(32'sh80000000, 32'h8, 1'b0, 0);
    push_item(32'sh7fffffff, 32'h9, 1'b1, 0);
    // Two equal keys, then a strictly descending set
    push_item(-32'sd5, 32'haaaaaaaa, 1'b0, 0);
    push_item(-32'sd5, 32'h55555555, 1'b1, 0);
    push_item(32'sd300, 32'h10, 1'b0, 0);
    push_item(32'sd200, 32'h11, 1'b0, 0);
    push_item(32'sd100, 32'h12, 1'b0, 0);
    push_item(-32'sd100, 32'h13, 1'b1, 0);

    // Store exactly full, then overflowing sets where the closing item is dropped
    push_random_set(STORE_DEPTH, 0, 1'b0);
    push_random_set(STORE_DEPTH + 1, 0, 1'b0);
    push_random_set(STORE_DEPTH + 3, 15, 1'b1);

    // Random sets, mostly small, phases of sender idling
    while (items_queued < TARGET_ITEMS) begin
      phase = (items_queued * 4) / TARGET_ITEMS;
      if (phase > 3) phase = 3;
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      push_random_set(size, pct_by_phase[phase], $urandom_range(0, 3) == 0);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (item_q.size() != 0 || start || sorted_exp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ihs_pkg.sv
hdl/ihs_ram.sv
hdl/int_heapsort_with_tags.sv
test/tb_top.sv
